FILE: rtl/kps_pkg.sv
package kps_pkg;

  localparam int PATTERN_SIDE  = 1024;
  localparam int HALF_SIDE     = PATTERN_SIDE / 2;
  localparam int MAX_FOCI      = 64;
  localparam int PHASE_BITS    = 16;
  localparam int CORDIC_STEPS  = 16;
  localparam int CORDIC_STAGES = CORDIC_STEPS / 2;
  localparam int SUM_BITS      = 11;
  localparam int LATENCY       = CORDIC_STAGES + 3;
  localparam int CFG_DATA_W    = 32;

  typedef enum logic [2:0] {
    REG_FOCUS_COUNT,
    REG_PASS_INDEX,
    REG_HALF_SIZE,
    REG_CHARGE,
    REG_PHASE_OFFSET,
    REG_LENS_COEF,
    REG_RAMP_ROW_COEF,
    REG_RAMP_COL_COEF
  } kps_reg_t;

  typedef struct packed {
    logic [9:0]  row;
    logic [9:0]  col;
    logic [15:0] old_phase;
  } kps_in_t;

  typedef struct packed {
    logic [15:0] new_phase;
    logic        applied;
  } kps_out_t;

  // one pipeline slot: vortex angle, interleave remainder and lens/ramp sum in parallel
  typedef struct packed {
    logic               valid;
    logic               center;
    logic signed [29:0] x;
    logic signed [29:0] y;
    logic [31:0]        ang;
    logic signed [11:0] dx;
    logic signed [11:0] dy;
    logic [10:0]        sum;
    logic [6:0]         rem;
    logic [15:0]        base;
    logic [21:0]        r2;
    logic [31:0]        pdx;
    logic [31:0]        pdy;
    logic [31:0]        plr;
    logic [15:0]        quad;
    logic [15:0]        vort;
    logic               applied;
  } kps_stage_t;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2FA;
      15:      v = 32'h0000517D;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/kinoform_phase_superpose.sv
// channel   | ports                          | transfer at rising edge
// ----------+--------------------------------+-------------------------------
// input     | start, busy, in_data           | start high and busy low
// result    | out_valid, out_data            | every cycle out_valid is high
// config    | cfg_we, cfg_index, cfg_wdata   | cfg_we high
//
// one pixel enters per clock; each result passes through the 16-step cordic
// pipeline (two steps per stage) plus the entry, vortex multiply and final add
// stages
// rst_n is synchronous; busy is high only while reset is held
// the receiver cannot stall, so the pipeline advances every cycle and never holds
module kinoform_phase_superpose (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  kps_pkg::kps_in_t                  in_data,
  output logic                              out_valid,
  output kps_pkg::kps_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [kps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import kps_pkg::*;

  // configuration registers
  logic [6:0]         focus_count_r;
  logic [5:0]         pass_index_r;
  logic [9:0]         half_size_r;
  logic signed [7:0]  charge_r;
  logic [15:0]        phase_offset_r;
  logic signed [31:0] lens_coef_r;
  logic signed [31:0] ramp_row_r;
  logic signed [31:0] ramp_col_r;

  logic [6:0]  fc_sat;
  logic [9:0]  hs_sat;
  logic        in_accept;

  kps_stage_t  pipe_r   [0:LATENCY-2];
  kps_stage_t  pipe_nxt [0:LATENCY-2];

  logic        out_valid_r;
  kps_out_t    out_data_r;
  kps_out_t    out_data_nxt;

  assign busy      = ~rst_n;
  assign in_accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focus_count_r  <= 7'd1;
      pass_index_r   <= '0;
      half_size_r    <= 10'(HALF_SIDE);
      charge_r       <= '0;
      phase_offset_r <= '0;
      lens_coef_r    <= '0;
      ramp_row_r     <= '0;
      ramp_col_r     <= '0;
    end else if (cfg_we) begin
      unique case (kps_reg_t'(cfg_index))
        REG_FOCUS_COUNT:   focus_count_r  <= cfg_wdata[6:0];
        REG_PASS_INDEX:    pass_index_r   <= cfg_wdata[5:0];
        REG_HALF_SIZE:     half_size_r    <= cfg_wdata[9:0];
        REG_CHARGE:        charge_r       <= cfg_wdata[7:0];
        REG_PHASE_OFFSET:  phase_offset_r <= cfg_wdata[15:0];
        REG_LENS_COEF:     lens_coef_r    <= cfg_wdata[31:0];
        REG_RAMP_ROW_COEF: ramp_row_r     <= cfg_wdata[31:0];
        REG_RAMP_COL_COEF: ramp_col_r     <= cfg_wdata[31:0];
      endcase
    end
  end

  // zero focus count acts as one, large counts and half sizes saturate
  assign fc_sat = (focus_count_r == 7'd0) ? 7'd1 :
                  (focus_count_r > 7'(MAX_FOCI)) ? 7'(MAX_FOCI) : focus_count_r;
  assign hs_sat = (half_size_r > 10'(HALF_SIDE)) ? 10'(HALF_SIDE) : half_size_r;

  // entry: offsets from the centre and quarter-turn prerotation into the right half plane
  always_comb begin
    logic signed [11:0] dx;
    logic signed [11:0] dy;
    logic signed [11:0] px;
    logic signed [11:0] py;
    logic [31:0]        a0;
    dx = $signed({2'b00, in_data.col}) - $signed({2'b00, hs_sat});
    dy = $signed({2'b00, in_data.row}) - $signed({2'b00, hs_sat});
    px = dx;
    py = dy;
    a0 = 32'h0;
    if (dx < 0) begin
      if (dy >= 0) begin
        px = dy;
        py = -dx;
        a0 = 32'h40000000;
      end else begin
        px = -dy;
        py = dx;
        a0 = 32'hC0000000;
      end
    end
    pipe_nxt[0]        = '0;
    pipe_nxt[0].valid  = in_accept;
    pipe_nxt[0].center = (dx == 12'sd0) && (dy == 12'sd0);
    pipe_nxt[0].x      = {{2{px[11]}}, px, 16'h0000};
    pipe_nxt[0].y      = {{2{py[11]}}, py, 16'h0000};
    pipe_nxt[0].ang    = a0;
    pipe_nxt[0].dx     = dx;
    pipe_nxt[0].dy     = dy;
    pipe_nxt[0].sum    = {1'b0, in_data.row} + {1'b0, in_data.col};
    pipe_nxt[0].base   = (pass_index_r == 6'd0) ? 16'h0000 : in_data.old_phase;
  end

  // cordic, remainder and lens/ramp stages, two cordic steps and up to two remainder bits per stage
  for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_stage
    always_comb begin
      kps_stage_t         s;
      logic signed [29:0] xs;
      logic signed [29:0] ys;
      logic [7:0]         t;
      logic signed [23:0] sq;
      logic [31:0]        sfull;
      int unsigned        i;
      s = pipe_r[k-1];
      for (int j = 0; j < 2; j++) begin
        i  = 2 * (k - 1) + j;
        xs = s.x >>> i;
        ys = s.y >>> i;
        if (s.y > 0) begin
          s.x   = s.x + ys;
          s.y   = s.y - xs;
          s.ang = s.ang + atan_turn(i);
        end else begin
          s.x   = s.x - ys;
          s.y   = s.y + xs;
          s.ang = s.ang - atan_turn(i);
        end
        // restoring remainder of row+col by the focus count, msb first
        if (i < SUM_BITS) begin
          t = {s.rem, s.sum[SUM_BITS-1-i]};
          if (t >= {1'b0, fc_sat}) t = t - {1'b0, fc_sat};
          s.rem = t[6:0];
        end
      end
      sq    = '0;
      sfull = '0;
      if (k == 1) begin
        sq    = s.dx * s.dx + s.dy * s.dy;
        s.r2  = sq[21:0];
        s.pdy = ramp_row_r * s.dy;
        s.pdx = ramp_col_r * s.dx;
      end else if (k == 2) begin
        // only the low 32 bits of the lens product and of the ramp sum are kept
        s.plr = lens_coef_r * $signed({1'b0, s.r2});
        s.pdx = s.pdx + s.pdy;
      end else if (k == 3) begin
        sfull  = s.plr + s.pdx + 32'h00008000;
        s.quad = sfull[31:16];
      end
      pipe_nxt[k] = s;
    end
  end

  // vortex term and class match
  always_comb begin
    kps_stage_t         s;
    logic [15:0]        ang_rnd;
    logic signed [24:0] prod;
    s = pipe_r[CORDIC_STAGES];
    if (s.center) s.ang = 32'h0;
    ang_rnd   = s.ang[31:16] + {15'h0, s.ang[15]};
    prod      = charge_r * $signed({1'b0, ang_rnd});
    s.vort    = prod[15:0];
    s.applied = (s.rem == {1'b0, pass_index_r});
    pipe_nxt[CORDIC_STAGES+1] = s;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= LATENCY - 2; k++) begin
      if (!rst_n) begin
        pipe_r[k] <= '0;
      end else begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  // final sum, wraps mod one turn; pixels of other classes keep their base phase
  always_comb begin
    kps_stage_t s;
    s = pipe_r[LATENCY-2];
    out_data_nxt.applied   = s.applied;
    out_data_nxt.new_phase = s.applied ? (s.base + s.vort + s.quad + phase_offset_r) : s.base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pipe_r[LATENCY-2].valid;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##(LATENCY) out_valid)
    else $error("accepted pixel gave no result");

  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, LATENCY))
    else $error("result without an accepted pixel");

  a_center_no_vortex : assert property (@(posedge clk) disable iff (!rst_n)
    pipe_r[LATENCY-2].valid && pipe_r[LATENCY-2].center |-> pipe_r[LATENCY-2].vort == 16'h0)
    else $error("centre pixel got a vortex term");

endmodule
